### hdl/quadtree_tile_cache_lru_macros.svh
// assertion macros for the tile cache top level
`ifndef QUADTREE_TILE_CACHE_LRU_MACROS_SVH
`define QUADTREE_TILE_CACHE_LRU_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on aclk, off during reset
`define QTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qtc assertion failed");
// next-cycle implication, sampled on aclk, off during reset
`define QTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qtc assertion failed");
`else
`define QTC_ASSERT_NOW(lbl, ante, cons)
`define QTC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/qtc_pkg.sv
`default_nettype none
package qtc_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int MIN_ZOOM    = 0;
    localparam int MAX_ZOOM    = 20;
    localparam int PIN_SLOTS   = 16;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PIN_W  = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_PIN    = 2'd2;
    localparam logic [1:0] MODE_UNPIN  = 2'd3;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_MISS    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PIN,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [4:0]  z;
        logic [19:0] y;
        logic [19:0] x;
    } key_t;

    // search results rippling along the row of cells
    typedef struct packed {
        logic              match_found;
        logic [SLOT_W-1:0] match_idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic              vic_found;
        logic [SLOT_W-1:0] vic_idx;
        logic [63:0]       vic_stamp;
        key_t              vic_key;
        logic              hit_found;
        logic [SLOT_W-1:0] hit_idx;
        key_t              hit_key;
    } carry_t;

    // broadcast updates from the controller to the cells
    typedef struct packed {
        logic              wr_en;
        logic              ref_en;
        logic [SLOT_W-1:0] idx;
        logic [63:0]       stamp;
        logic              wr_pinned;
        logic              pin_set;
        logic              pin_clr;
    } cell_cmd_t;

    typedef struct packed {
        logic             found;
        logic [PIN_W-1:0] found_idx;
        logic             free_found;
        logic [PIN_W-1:0] free_idx;
    } pin_info_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [19:0] hit_x;
        logic [19:0] hit_y;
        logic [4:0]  hit_zoom;
        logic [4:0]  level_shift;
        logic [19:0] offset_x;
        logic [19:0] offset_y;
        logic        evicted_valid;
        logic [19:0] evicted_x;
        logic [19:0] evicted_y;
        logic [4:0]  evicted_zoom;
    } res_t;

endpackage
`default_nettype wire

### hdl/qtc_cell.sv
`default_nettype none
module qtc_cell
    import qtc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SLOT_W-1:0] cell_idx,
    input  wire key_t              probe,
    input  wire cell_cmd_t         cmd,
    input  wire carry_t            carry_in,
    output      carry_t            carry_out
);

    logic        valid_reg, valid_next;
    logic        pinned_reg, pinned_next;
    key_t        key_reg, key_next;
    logic [63:0] stamp_reg, stamp_next;
    carry_t      carry_reg, carry_next;

    logic       sel;
    logic       key_eq;
    logic [4:0] sh;
    logic       anc;

    always_comb begin
        sel    = (cell_idx == cmd.idx);
        key_eq = valid_reg && (key_reg == probe);
        sh     = probe.z - key_reg.z;
        anc    = valid_reg && (key_reg.z <= probe.z)
                 && ((probe.x >> sh) == key_reg.x)
                 && ((probe.y >> sh) == key_reg.y);

        carry_next = carry_in;
        if (key_eq && !carry_in.match_found) begin
            carry_next.match_found = 1'b1;
            carry_next.match_idx   = cell_idx;
        end
        if (!valid_reg && !carry_in.free_found) begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = cell_idx;
        end
        // strict compare keeps the lowest slot on equal stamps
        if (!pinned_reg && (!carry_in.vic_found || stamp_reg < carry_in.vic_stamp)) begin
            carry_next.vic_found = 1'b1;
            carry_next.vic_idx   = cell_idx;
            carry_next.vic_stamp = stamp_reg;
            carry_next.vic_key   = key_reg;
        end
        // deepest resident ancestor wins
        if (anc && (!carry_in.hit_found || key_reg.z > carry_in.hit_key.z)) begin
            carry_next.hit_found = 1'b1;
            carry_next.hit_idx   = cell_idx;
            carry_next.hit_key   = key_reg;
        end

        valid_next  = valid_reg;
        pinned_next = pinned_reg;
        key_next    = key_reg;
        stamp_next  = stamp_reg;
        if (cmd.wr_en && sel) begin
            valid_next  = 1'b1;
            pinned_next = cmd.wr_pinned;
            key_next    = probe;
            stamp_next  = cmd.stamp;
        end
        if (cmd.ref_en && sel) begin
            stamp_next = cmd.stamp;
        end
        if (cmd.pin_set && key_eq) begin
            pinned_next = 1'b1;
        end
        if (cmd.pin_clr && key_eq) begin
            pinned_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            pinned_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            pinned_reg <= pinned_next;
        end
        key_reg   <= key_next;
        stamp_reg <= stamp_next;
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule
`default_nettype wire

### hdl/qtc_pin_set.sv
`default_nettype none
module qtc_pin_set
    import qtc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire key_t probe,
    input  wire logic set_en,
    input  wire logic clr_en,
    output      pin_info_t info
);

    logic [PIN_SLOTS-1:0] valid_reg, valid_next;
    key_t                 key_reg  [PIN_SLOTS];

    // descending loop so the lowest entry wins
    always_comb begin
        info = '0;
        for (int i = PIN_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == probe) begin
                info.found     = 1'b1;
                info.found_idx = PIN_W'(i);
            end
            if (!valid_reg[i]) begin
                info.free_found = 1'b1;
                info.free_idx   = PIN_W'(i);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (set_en) begin
            valid_next[info.free_idx] = 1'b1;
        end
        if (clr_en) begin
            valid_next[info.found_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (set_en) begin
            key_reg[info.free_idx] <= probe;
        end
    end

endmodule
`default_nettype wire

### hdl/quadtree_tile_cache_lru.sv
// insert and lookup scan the whole row of cells, the search rippling through
// one cell per cycle, and register their result in the finish state
// pin and unpin pass the pin state; a bad key or grid goes straight to output
// a new transaction is taken only once the last result is in the output register
// reset: aresetn low at a clock edge empties the table, the pin set and the
// use counter; no clearing pass is needed
`default_nettype none
`include "quadtree_tile_cache_lru_macros.svh"
module quadtree_tile_cache_lru
    import qtc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input transactions
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [47:0]  s_tdata,  // tile_x, tile_y, tile_zoom, zero pad
    input  wire logic [2:0]   s_tuser,  // mode, grid_valid
    // result transactions
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // slot, hit_x, hit_y, hit_zoom, level_shift, offset_x, offset_y,
    // evicted_x, evicted_y, evicted_zoom, zero pad
    output      logic [143:0] m_tdata,
    output      logic [2:0]   m_tuser   // status, evicted_valid
);

    // controller state
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    key_t              key_reg, key_next;
    logic [1:0]        mode_reg, mode_next;
    logic [63:0]       ctr_reg, ctr_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // incoming transaction fields
    key_t       in_key;
    logic [1:0] in_mode;
    logic       in_gv;
    logic       in_ok;
    logic       in_accept;

    // row of cells
    carry_t    chain [TABLE_SLOTS];
    carry_t    fin;
    cell_cmd_t cmd;

    // pin set
    pin_info_t pin_info;
    logic      pin_set_en;
    logic      pin_clr_en;

    logic [4:0]  sh;
    logic [19:0] lo_mask;
    logic        ctr_inc;

    assign in_key.x  = s_tdata[19:0];
    assign in_key.y  = s_tdata[39:20];
    assign in_key.z  = s_tdata[44:40];
    assign in_mode   = s_tuser[1:0];
    assign in_gv     = s_tuser[2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // key is valid when the zoom is in range and x, y fit that zoom
    assign in_ok = (in_key.z >= 5'(MIN_ZOOM)) && (in_key.z <= 5'(MAX_ZOOM))
                   && ((in_key.x >> in_key.z) == 20'd0)
                   && ((in_key.y >> in_key.z) == 20'd0);

    // every cell sees the latched key; searches ripple from slot zero upward
    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        carry_t cin;
        if (i == 0) begin : g_head
            assign cin = '0;
        end else begin : g_link
            assign cin = chain[i-1];
        end
        qtc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (SLOT_W'(i)),
            .probe     (key_reg),
            .cmd       (cmd),
            .carry_in  (cin),
            .carry_out (chain[i])
        );
    end

    assign fin = chain[TABLE_SLOTS-1];

    qtc_pin_set u_pins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .probe   (key_reg),
        .set_en  (pin_set_en),
        .clr_en  (pin_clr_en),
        .info    (pin_info)
    );

    // sub-tile offset is the low level_shift bits of the key
    assign sh      = key_reg.z - fin.hit_key.z;
    assign lo_mask = ~(20'hFFFFF << sh);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        mode_next     = mode_reg;
        ctr_next      = ctr_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.stamp     = ctr_reg + 64'd1;
        pin_set_en    = 1'b0;
        pin_clr_en    = 1'b0;
        ctr_inc       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    key_next  = in_key;
                    mode_next = in_mode;
                    res_next  = '0;
                    cnt_next  = '0;
                    if (!in_ok || (in_mode == MODE_INSERT && !in_gv)) begin
                        res_next.status = STATUS_INVALID;
                        state_next      = ST_OUT;
                    end else if (in_mode == MODE_PIN || in_mode == MODE_UNPIN) begin
                        state_next = ST_PIN;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + SLOT_W'(1);
                if (cnt_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (mode_reg == MODE_INSERT) begin
                    // refresh, then lowest free slot, then oldest unpinned
                    if (fin.match_found) begin
                        cmd.wr_en = 1'b1;
                        cmd.idx   = fin.match_idx;
                    end else if (fin.free_found) begin
                        cmd.wr_en = 1'b1;
                        cmd.idx   = fin.free_idx;
                    end else if (fin.vic_found) begin
                        cmd.wr_en              = 1'b1;
                        cmd.idx                = fin.vic_idx;
                        res_next.evicted_valid = 1'b1;
                        res_next.evicted_x     = fin.vic_key.x;
                        res_next.evicted_y     = fin.vic_key.y;
                        res_next.evicted_zoom  = fin.vic_key.z;
                    end else begin
                        res_next.status = STATUS_FULL;
                    end
                    cmd.wr_pinned = pin_info.found;
                    if (cmd.wr_en) begin
                        ctr_inc       = 1'b1;
                        res_next.slot = 6'(cmd.idx);
                    end
                end else begin
                    if (fin.hit_found) begin
                        cmd.ref_en           = 1'b1;
                        cmd.idx              = fin.hit_idx;
                        ctr_inc              = 1'b1;
                        res_next.slot        = 6'(fin.hit_idx);
                        res_next.hit_x       = fin.hit_key.x;
                        res_next.hit_y       = fin.hit_key.y;
                        res_next.hit_zoom    = fin.hit_key.z;
                        res_next.level_shift = sh;
                        res_next.offset_x    = key_reg.x & lo_mask;
                        res_next.offset_y    = key_reg.y & lo_mask;
                    end else begin
                        res_next.status = STATUS_MISS;
                    end
                end
                if (ctr_inc) begin
                    ctr_next = ctr_reg + 64'd1;
                end
                state_next = ST_OUT;
            end
            ST_PIN: begin
                if (mode_reg == MODE_PIN) begin
                    if (!pin_info.found) begin
                        if (pin_info.free_found) begin
                            pin_set_en  = 1'b1;
                            cmd.pin_set = 1'b1;
                        end else begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                end else if (pin_info.found) begin
                    pin_clr_en  = 1'b1;
                    cmd.pin_clr = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ctr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ctr_reg      <= ctr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg  <= key_next;
        mode_reg <= mode_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_reg.evicted_valid, out_reg.status};
    assign m_tdata  = {3'd0, out_reg.evicted_zoom, out_reg.evicted_y, out_reg.evicted_x,
                       out_reg.offset_y, out_reg.offset_x, out_reg.level_shift,
                       out_reg.hit_zoom, out_reg.hit_y, out_reg.hit_x, out_reg.slot};

    // every stamp taken advances the use counter by exactly one
    `QTC_ASSERT_NXT(a_ctr_step, ctr_inc, ctr_reg == $past(ctr_reg) + 64'd1)
    // a result only appears after the output hand-off state
    `QTC_ASSERT_NOW(a_out_src, $rose(m_tvalid_reg), $past(state_reg) == ST_OUT)
    // the ripple counter never runs past the last cell
    `QTC_ASSERT_NOW(a_cnt_rng, state_reg == ST_SCAN, cnt_reg <= SLOT_W'(TABLE_SLOTS - 1))
    // an accepted transaction always leaves the idle state
    `QTC_ASSERT_NXT(a_acc_busy, in_accept, state_reg != ST_IDLE)

endmodule
`default_nettype wire
